>>> hdl/osis_pkg.sv
package osis_pkg;

  // Fixed field widths of one item and one result
  localparam int unsigned VALUE_W = 11;
  localparam int unsigned RANK_W  = 16;

  // Which walk the shared step unit serves
  typedef enum logic {
    OP_INSERT,
    OP_SELECT
  } step_op_e;

endpackage

>>> hdl/osis_count_ram.sv
module osis_count_ram #(
  parameter int unsigned DEPTH   = 4096,
  parameter int unsigned ADDR_W  = 12,
  parameter int unsigned DATA_W  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              clearing_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              clearing_q, clearing_d;

  // Clearing sweep after reset: one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  // Write port, sweep has priority
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

  assign clearing_o = clearing_q;

endmodule

>>> hdl/osis_step.sv
module osis_step
  import osis_pkg::*;
#(
  parameter int unsigned IDX_W  = 10,
  parameter int unsigned NODE_W = 12,
  parameter int unsigned CNT_W  = 16
) (
  input  step_op_e          op_i,
  input  logic [IDX_W-1:0]  lo_i,
  input  logic [IDX_W-1:0]  hi_i,
  input  logic [NODE_W-1:0] node_i,
  input  logic [IDX_W-1:0]  pos_i,
  input  logic [RANK_W-1:0] k_i,
  input  logic [CNT_W-1:0]  cnt_i,
  output logic [CNT_W-1:0]  cnt_inc_o,
  output logic              at_leaf_o,
  output logic [IDX_W-1:0]  lo_o,
  output logic [IDX_W-1:0]  hi_o,
  output logic [NODE_W-1:0] node_o,
  output logic [RANK_W-1:0] k_o,
  output logic              leaf_o
);

  localparam int unsigned CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] mid;
  logic             go_right;

  // Split point of the current range
  assign sum = {1'b0, lo_i} + {1'b0, hi_i};
  assign mid = sum[IDX_W:1];

  // Direction: by position on insert, by rank against left count on select
  always_comb begin
    case (op_i)
      OP_INSERT: go_right = (pos_i > mid);
      default:   go_right = (CMP_W'(k_i) > CMP_W'(cnt_i));
    endcase
  end

  assign cnt_inc_o = cnt_i + CNT_W'(1);
  assign at_leaf_o = (lo_i >= hi_i);
  assign lo_o      = go_right ? (mid + IDX_W'(1)) : lo_i;
  assign hi_o      = go_right ? hi_i : mid;
  assign node_o    = {node_i[NODE_W-2:0], go_right};
  assign k_o       = go_right ? (k_i - RANK_W'(cnt_i)) : k_i;
  assign leaf_o    = (lo_o >= hi_o);

endmodule

>>> hdl/order_statistic_insert_select.sv
// Order-statistic count tree: each item inserts one value into a multiset
// of values 1..NUM_VALUES, then selects the query_rank-th smallest value.
// Channels: an item is taken at a rising edge with start high and busy low.
// The result (kth_value_o, rank_valid_o, insert_dropped_o) is shown for one
// cycle with result_valid_o high; the receiver cannot stall it.
// The root is read, then the insert path is walked one node per cycle
// (read-modify-write on the count memory), then the select path one level
// per cycle through the same step unit; when no insert is made, the insert
// walk is skipped. busy drops in the strobe cycle, so the next item may
// enter then; one item is in flight at a time.
// Reset: the count memory (4*NUM_VALUES entries) is cleared by a sweep over
// every entry, during which busy is high.
// A full tree (root at 2^COUNT_BITS - 1) drops the insert and flags it;
// a value outside 1..NUM_VALUES is ignored without a flag.
module order_statistic_insert_select
  import osis_pkg::*;
#(
  parameter int unsigned NUM_VALUES = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] insert_value_i,
  input  logic [RANK_W-1:0]  query_rank_i,
  output logic               result_valid_o,
  output logic [VALUE_W-1:0] kth_value_o,
  output logic               rank_valid_o,
  output logic               insert_dropped_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_VALUES);
  localparam int unsigned DEPTH  = 4 * NUM_VALUES;
  localparam int unsigned NODE_W = $clog2(DEPTH);
  localparam int unsigned PW     = ((IDX_W > VALUE_W) ? IDX_W : VALUE_W) + 1;
  localparam int unsigned KW     = ((IDX_W + 1) > VALUE_W) ? (IDX_W + 1) : VALUE_W;
  localparam int unsigned CMP_W  = (COUNT_BITS > RANK_W) ? COUNT_BITS : RANK_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROOT,
    S_INS,
    S_SEL_ADDR,
    S_SEL
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    lo_q, lo_d, hi_q, hi_d, pos_q, pos_d;
  logic [NODE_W-1:0]   node_q, node_d;
  logic [RANK_W-1:0]   k_q, k_d, rank_q, rank_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic                in_range_q, in_range_d;
  logic                dropped_q, dropped_d;
  logic                res_valid_q, res_valid_d;
  logic [VALUE_W-1:0]  kth_q, kth_d;
  logic                rank_ok_q, rank_ok_d;

  logic [PW-1:0]       val_ext;
  logic [KW-1:0]       found;

  // Memory port signals
  logic                  ram_we;
  logic [NODE_W-1:0]     ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
  logic                  ram_clearing;

  // Step unit signals
  step_op_e              op;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  at_leaf, leaf_n;
  logic [IDX_W-1:0]      lo_n, hi_n;
  logic [NODE_W-1:0]     node_n;
  logic [RANK_W-1:0]     k_n;

  osis_count_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (NODE_W),
    .DATA_W (COUNT_BITS)
  ) u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (ram_we),
    .waddr_i    (ram_waddr),
    .wdata_i    (ram_wdata),
    .raddr_i    (ram_raddr),
    .rdata_o    (ram_rdata),
    .clearing_o (ram_clearing)
  );

  assign op = (state_q == S_INS) ? OP_INSERT : OP_SELECT;

  osis_step #(
    .IDX_W  (IDX_W),
    .NODE_W (NODE_W),
    .CNT_W  (COUNT_BITS)
  ) u_step (
    .op_i      (op),
    .lo_i      (lo_q),
    .hi_i      (hi_q),
    .node_i    (node_q),
    .pos_i     (pos_q),
    .k_i       (k_q),
    .cnt_i     (ram_rdata),
    .cnt_inc_o (cnt_inc),
    .at_leaf_o (at_leaf),
    .lo_o      (lo_n),
    .hi_o      (hi_n),
    .node_o    (node_n),
    .k_o       (k_n),
    .leaf_o    (leaf_n)
  );

  assign val_ext = PW'(insert_value_i);
  assign found   = KW'(lo_n) + KW'(1);

  // Sequencer: wait for the clearing sweep, root check, insert walk, select walk
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    node_d      = node_q;
    k_d         = k_q;
    pos_d       = pos_q;
    rank_d      = rank_q;
    total_d     = total_q;
    in_range_d  = in_range_q;
    dropped_d   = dropped_q;
    res_valid_d = 1'b0;
    kth_d       = kth_q;
    rank_ok_d   = rank_ok_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = cnt_inc;
    ram_raddr   = NODE_W'(1);

    unique case (state_q)
      S_CLEAR: begin
        if (!ram_clearing) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          pos_d      = IDX_W'(val_ext - PW'(1));
          in_range_d = (val_ext != '0) && (val_ext <= PW'(NUM_VALUES));
          rank_d     = query_rank_i;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        // root count in ram_rdata; node 1 is read again for the insert walk
        lo_d      = '0;
        hi_d      = IDX_W'(NUM_VALUES - 1);
        node_d    = NODE_W'(1);
        dropped_d = in_range_q && (ram_rdata == '1);
        if (in_range_q && (ram_rdata != '1)) begin
          total_d = cnt_inc;
          state_d = S_INS;
        end else begin
          total_d = ram_rdata;
          state_d = S_SEL_ADDR;
        end
      end
      S_INS: begin
        ram_we = 1'b1;
        if (at_leaf) begin
          state_d = S_SEL_ADDR;
        end else begin
          lo_d      = lo_n;
          hi_d      = hi_n;
          node_d    = node_n;
          ram_raddr = node_n;
        end
      end
      S_SEL_ADDR: begin
        lo_d      = '0;
        hi_d      = IDX_W'(NUM_VALUES - 1);
        node_d    = NODE_W'(1);
        k_d       = rank_q;
        ram_raddr = NODE_W'(2);
        state_d   = S_SEL;
      end
      S_SEL: begin
        // ram_rdata holds the left child count
        lo_d      = lo_n;
        hi_d      = hi_n;
        node_d    = node_n;
        k_d       = k_n;
        ram_raddr = {node_n[NODE_W-2:0], 1'b0};
        if (leaf_n) begin
          res_valid_d = 1'b1;
          kth_d       = found[VALUE_W-1:0];
          rank_ok_d   = (rank_q != '0) && (CMP_W'(rank_q) <= CMP_W'(total_q));
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, walk registers and result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      res_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      node_q      <= '0;
      k_q         <= '0;
      pos_q       <= '0;
      rank_q      <= '0;
      total_q     <= '0;
      in_range_q  <= 1'b0;
      dropped_q   <= 1'b0;
      kth_q       <= '0;
      rank_ok_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      node_q      <= node_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      rank_q      <= rank_d;
      total_q     <= total_d;
      in_range_q  <= in_range_d;
      dropped_q   <= dropped_d;
      kth_q       <= kth_d;
      rank_ok_q   <= rank_ok_d;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = res_valid_q;
  assign kth_value_o      = kth_q;
  assign rank_valid_o     = rank_ok_q;
  assign insert_dropped_o = dropped_q;

endmodule
